/* rtl/assert_macros.svh */
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication with reset disable
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication with reset disable
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sae_pkg.sv */
package sae_pkg;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_RDTOP = 3'd2,
        OP_RDBOT = 3'd3,
        OP_ADD   = 3'd4,
        OP_SUB   = 3'd5,
        OP_MUL   = 3'd6,
        OP_DIV   = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FEW     = 3'd2,
        ST_RANGE   = 3'd3,
        ST_DIVZERO = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RD1,
        BK_RD2,
        BK_MUL,
        BK_DIV,
        BK_FIX,
        BK_DONE
    } t_bk_state;

    localparam int IN_VALUE_W = 32;
    localparam int IN_INDEX_W = 10;
    localparam int OUT_RES_W  = 32;
    localparam int OUT_OCC_W  = 11;

endpackage

/* rtl/sae_front.sv */
module sae_front import sae_pkg::*; #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2:0]            i_operation,
    input  logic [IN_VALUE_W-1:0] i_value,
    input  logic [IN_INDEX_W-1:0] i_index,
    input  logic                  i_q_full,
    output logic                  o_busy,
    output logic                  o_q_wr,
    output t_op                   o_q_op,
    output logic [WORD_WIDTH-1:0] o_q_value,
    output logic [IN_INDEX_W-1:0] o_q_index
);

    logic [WORD_WIDTH-1:0] w_val;

    // sign extend then wrap to the word
    always_comb begin
        logic [63:0] ext;
        ext   = {{(64-IN_VALUE_W){i_value[IN_VALUE_W-1]}}, i_value};
        w_val = ext[WORD_WIDTH-1:0];
    end

    assign o_busy    = i_q_full;
    assign o_q_wr    = i_start && !i_q_full && i_rst_n;
    assign o_q_op    = t_op'(i_operation);
    assign o_q_value = w_val;
    assign o_q_index = i_index;

endmodule

/* rtl/sae_queue.sv */
module sae_queue import sae_pkg::*; #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  t_op                   i_op,
    input  logic [WORD_WIDTH-1:0] i_value,
    input  logic [IN_INDEX_W-1:0] i_index,
    input  logic                  i_rd,
    output logic                  o_full,
    output logic                  o_empty,
    output t_op                   o_op,
    output logic [WORD_WIDTH-1:0] o_value,
    output logic [IN_INDEX_W-1:0] o_index
);

    // two-entry command queue
    t_op                   r_op  [2];
    logic [WORD_WIDTH-1:0] r_val [2];
    logic [IN_INDEX_W-1:0] r_idx [2];
    logic                  r_wp, r_rp;
    logic [1:0]            r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_op[r_wp]  <= i_op;
                r_val[r_wp] <= i_value;
                r_idx[r_wp] <= i_index;
                r_wp        <= ~r_wp;
            end
            if (i_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_op    = r_op[r_rp];
    assign o_value = r_val[r_rp];
    assign o_index = r_idx[r_rp];

endmodule

/* rtl/sae_back.sv */
module sae_back import sae_pkg::*; #(
    parameter int STACK_DEPTH = 1024,
    parameter int WORD_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  t_op                   i_op,
    input  logic [WORD_WIDTH-1:0] i_value,
    input  logic [IN_INDEX_W-1:0] i_index,
    output logic                  o_q_rd,
    output logic                  o_done,
    output logic [OUT_RES_W-1:0]  o_result,
    output logic [2:0]            o_status,
    output logic [OUT_OCC_W-1:0]  o_occupancy
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DCW = $clog2(WORD_WIDTH + 1);

    logic [WORD_WIDTH-1:0] mem [STACK_DEPTH];

    t_bk_state             r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    t_op                   r_op;
    logic [WORD_WIDTH-1:0] r_val;
    logic [WORD_WIDTH-1:0] r_x, r_y, n_x, n_y;
    logic [WORD_WIDTH-1:0] r_res, n_res;
    t_status               r_st, n_st;
    logic [WORD_WIDTH-1:0] r_q, n_q, r_rem, n_rem;
    logic [DCW-1:0]        r_dc, n_dc;
    logic                  r_neg, n_neg;
    logic                  r_done;
    logic [WORD_WIDTH-1:0] r_rdata;

    logic                  w_we;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [WORD_WIDTH-1:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    function automatic logic [WORD_WIDTH-1:0] mag(input logic [WORD_WIDTH-1:0] w);
        mag = w[WORD_WIDTH-1] ? (~w + 1'b1) : w;
    endfunction

    logic [CW-1:0]         w_idx_ext;
    logic                  w_in_range;
    logic [WORD_WIDTH:0]   w_trial;
    logic [2*WORD_WIDTH-1:0] w_prod;

    assign w_idx_ext  = CW'(i_index);
    assign w_in_range = ({{(32-IN_INDEX_W){1'b0}}, i_index} < 32'(r_cnt));
    assign w_trial    = {r_rem, r_q[WORD_WIDTH-1]} - {1'b0, mag(r_x)};
    assign w_prod     = r_y * r_x;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_x     = r_x;
        n_y     = r_y;
        n_res   = r_res;
        n_st    = r_st;
        n_q     = r_q;
        n_rem   = r_rem;
        n_dc    = r_dc;
        n_neg   = r_neg;
        o_q_rd  = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_cnt[AW-1:0];
        w_wdata = r_val;
        w_raddr = r_cnt[AW-1:0] - 1'b1;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_rd = 1'b1;
                    n_res  = '0;
                    n_st   = ST_OK;
                    n_state = BK_DONE;
                    unique case (i_op)
                        OP_PUSH: begin
                            if (32'(r_cnt) >= STACK_DEPTH) n_st = ST_FULL;
                            else begin
                                w_we    = 1'b1;
                                w_wdata = i_value;
                                n_cnt   = r_cnt + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (r_cnt == '0) n_st = ST_EMPTY;
                            else begin
                                n_cnt   = r_cnt - 1'b1;
                                n_state = BK_RD1;
                            end
                        end
                        OP_RDTOP: begin
                            if (!w_in_range) n_st = ST_RANGE;
                            else begin
                                w_raddr = AW'(r_cnt - 1'b1 - w_idx_ext);
                                n_state = BK_RD1;
                            end
                        end
                        OP_RDBOT: begin
                            if (!w_in_range) n_st = ST_RANGE;
                            else begin
                                w_raddr = AW'(w_idx_ext);
                                n_state = BK_RD1;
                            end
                        end
                        default: begin
                            if (r_cnt < CW'(2)) n_st = ST_FEW;
                            else n_state = BK_RD1;
                        end
                    endcase
                end
            end
            BK_RD1: begin
                if (r_op == OP_POP || r_op == OP_RDTOP || r_op == OP_RDBOT) begin
                    n_res   = r_rdata;
                    n_state = BK_DONE;
                end else begin
                    n_x     = r_rdata;
                    w_raddr = AW'(r_cnt - CW'(2));
                    n_state = BK_RD2;
                end
            end
            BK_RD2: begin
                n_y   = r_rdata;
                n_cnt = r_cnt - CW'(2);
                unique case (r_op)
                    OP_ADD: begin n_res = r_rdata + r_x; n_state = BK_FIX; end
                    OP_SUB: begin n_res = r_rdata - r_x; n_state = BK_FIX; end
                    OP_MUL: n_state = BK_MUL;
                    default: begin
                        if (r_x == '0) begin
                            n_st = ST_DIVZERO;
                            n_state = BK_DONE;
                        end else begin
                            n_neg = r_rdata[WORD_WIDTH-1] ^ r_x[WORD_WIDTH-1];
                            n_q   = mag(r_rdata);
                            n_rem = '0;
                            n_dc  = DCW'(WORD_WIDTH);
                            n_state = BK_DIV;
                        end
                    end
                endcase
            end
            BK_MUL: begin
                n_res   = w_prod[WORD_WIDTH-1:0];
                n_state = BK_FIX;
            end
            BK_DIV: begin
                // restoring divide, one quotient bit a cycle
                if (!w_trial[WORD_WIDTH]) begin
                    n_rem = w_trial[WORD_WIDTH-1:0];
                    n_q   = {r_q[WORD_WIDTH-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[WORD_WIDTH-2:0], r_q[WORD_WIDTH-1]};
                    n_q   = {r_q[WORD_WIDTH-2:0], 1'b0};
                end
                n_dc = r_dc - 1'b1;
                if (r_dc == DCW'(1)) begin
                    if (r_neg) n_res = ~(n_q + {{(WORD_WIDTH-1){1'b0}}, n_rem != '0}) + 1'b1;
                    else n_res = n_q;
                    n_state = BK_FIX;
                end
            end
            BK_FIX: begin
                // push the arithmetic result
                w_we    = 1'b1;
                w_waddr = r_cnt[AW-1:0];
                w_wdata = r_res;
                n_cnt   = r_cnt + 1'b1;
                n_state = BK_DONE;
            end
            BK_DONE: n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= (r_state == BK_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_op  <= i_op;
            r_val <= i_value;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_res <= n_res;
        r_st  <= n_st;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dc  <= n_dc;
        r_neg <= n_neg;
    end

    always_comb begin
        logic [63:0] ext;
        ext = {{(64-WORD_WIDTH){r_res[WORD_WIDTH-1]}}, r_res};
        o_result = ext[OUT_RES_W-1:0];
    end
    assign o_done      = r_done;
    assign o_status    = r_st;
    assign o_occupancy = OUT_OCC_W'(r_cnt);

endmodule

/* rtl/stack_arithmetic_engine.sv */
// channel   | handshake            | ports
// command   | i_start / busy low   | i_operation, i_value, i_index
// result    | o_done strobe, 1 clk | o_result, o_status, o_occupancy
//
// push and errors caught at issue: no memory read before the result
// divide by zero: after both reads; pop and reads: one read with registered data
// add and sub: two reads and a write back; mul also has a multiply state
// div: two reads, the one-bit-a-cycle divider, then the write back
// new words wait in a two-entry queue; busy rises only when the queue is full
// synchronous active-low reset empties the stack; results cannot be held off
module stack_arithmetic_engine import sae_pkg::*; #(
    parameter int STACK_DEPTH = 1024,
    parameter int WORD_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2:0]            i_operation,
    input  logic [IN_VALUE_W-1:0] i_value,
    input  logic [IN_INDEX_W-1:0] i_index,
    output logic                  busy,
    output logic                  o_done,
    output logic [OUT_RES_W-1:0]  o_result,
    output logic [2:0]            o_status,
    output logic [OUT_OCC_W-1:0]  o_occupancy
);

    // front to queue and queue to back
    logic                  w_wr, w_full, w_empty, w_rd;
    t_op                   w_fop, w_bop;
    logic [WORD_WIDTH-1:0] w_fval, w_bval;
    logic [IN_INDEX_W-1:0] w_fidx, w_bidx;

    sae_front #(.WORD_WIDTH(WORD_WIDTH)) u_front (
        .i_rst_n(i_rst_n), .i_start(i_start),
        .i_operation(i_operation), .i_value(i_value), .i_index(i_index),
        .i_q_full(w_full), .o_busy(busy), .o_q_wr(w_wr),
        .o_q_op(w_fop), .o_q_value(w_fval), .o_q_index(w_fidx)
    );

    // short queue decouples accept from execution
    sae_queue #(.WORD_WIDTH(WORD_WIDTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(w_wr), .i_op(w_fop),
        .i_value(w_fval), .i_index(w_fidx), .i_rd(w_rd),
        .o_full(w_full), .o_empty(w_empty),
        .o_op(w_bop), .o_value(w_bval), .o_index(w_bidx)
    );

    // stack memory, count and arithmetic
    sae_back #(.STACK_DEPTH(STACK_DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_empty(w_empty),
        .i_op(w_bop), .i_value(w_bval), .i_index(w_bidx), .o_q_rd(w_rd),
        .o_done(o_done), .o_result(o_result), .o_status(o_status),
        .o_occupancy(o_occupancy)
    );

endmodule

/* rtl/sae_checker.sv */
`include "assert_macros.svh"
module sae_checker import sae_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_done,
    input logic [2:0]           o_status,
    input logic [OUT_RES_W-1:0] o_result,
    input logic [OUT_OCC_W-1:0] o_occupancy
);

    `CHK_NEXT(a_single_strobe, i_clk, i_rst_n, o_done, !o_done, "two strobes in a row")
    `CHK_IMPL(a_err_zero, i_clk, i_rst_n, o_done && o_status != ST_OK, o_result == '0, "error word not zero")
    `CHK_IMPL(a_status_legal, i_clk, i_rst_n, o_done, o_status <= ST_FULL, "bad status code")
    `CHK_IMPL(a_empty_occ, i_clk, i_rst_n, o_done && o_status == ST_EMPTY, o_occupancy == '0, "empty with entries")

endmodule

bind stack_arithmetic_engine sae_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_done(o_done), .o_status(o_status),
    .o_result(o_result), .o_occupancy(o_occupancy)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import sae_pkg::*;

    // clock and reset
    logic i_clk;
    logic i_rst_n;

    // command side
    logic                  i_start;
    logic [2:0]            i_operation;
    logic [IN_VALUE_W-1:0] i_value;
    logic [IN_INDEX_W-1:0] i_index;
    logic                  busy;

    // result side
    logic                 o_done;
    logic [OUT_RES_W-1:0] o_result;
    logic [2:0]           o_status;
    logic [OUT_OCC_W-1:0] o_occupancy;

    localparam int DEPTH = 1024;

    // one command word and one result word
    typedef struct packed {
        t_op         op;
        logic [31:0] value;
        logic [9:0]  index;
    } t_cmd;

    typedef struct packed {
        logic [31:0] result;
        t_status     status;
        logic [10:0] occupancy;
    } t_rsp;

    t_cmd cmd_queue[$];
    t_rsp rsp_expected[$];

    // predictor copy of the stack
    logic [31:0] model_stack[DEPTH];
    int          model_count;

    int errors;
    int words_sent;
    int words_checked;
    bit stim_done;
    int op_hits[8];
    int status_hits[6];

    stack_arithmetic_engine uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_index     (i_index),
        .busy        (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // floor quotient on signed words; divisor nonzero
    function automatic logic [31:0] floor_quotient(logic [31:0] num, logic [31:0] den);
        logic [31:0] mag_n;
        logic [31:0] mag_d;
        logic [31:0] quo;
        logic [31:0] rem;
        logic        negative;
        mag_n    = num[31] ? -num : num;
        mag_d    = den[31] ? -den : den;
        quo      = mag_n / mag_d;
        rem      = mag_n % mag_d;
        negative = num[31] ^ den[31];
        if (negative) begin
            if (rem != 0) begin
                quo = quo + 1;
            end
            return -quo;
        end
        return quo;
    endfunction

    // apply one command to the predicted stack and log the expected word
    task automatic predict_stack_op(t_cmd c);
        t_rsp        r;
        logic [31:0] lhs;
        logic [31:0] rhs;
        r.result = '0;
        r.status = ST_OK;
        case (c.op)
            OP_PUSH: begin
                if (model_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    model_stack[model_count] = c.value;
                    model_count++;
                end
            end
            OP_POP: begin
                if (model_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    model_count--;
                    r.result = model_stack[model_count];
                end
            end
            OP_RDTOP: begin
                if (c.index >= model_count) r.status = ST_RANGE;
                else r.result = model_stack[model_count - 1 - c.index];
            end
            OP_RDBOT: begin
                if (c.index >= model_count) r.status = ST_RANGE;
                else r.result = model_stack[c.index];
            end
            default: begin
                if (model_count < 2) begin
                    r.status = ST_FEW;
                end else begin
                    rhs = model_stack[model_count - 1];
                    lhs = model_stack[model_count - 2];
                    model_count -= 2;
                    case (c.op)
                        OP_ADD: r.result = lhs + rhs;
                        OP_SUB: r.result = lhs - rhs;
                        OP_MUL: r.result = lhs * rhs;
                        default: begin
                            if (rhs == 0) r.status = ST_DIVZERO;
                            else r.result = floor_quotient(lhs, rhs);
                        end
                    endcase
                    if (r.status == ST_OK) begin
                        model_stack[model_count] = r.result;
                        model_count++;
                    end
                end
            end
        endcase
        r.occupancy = model_count[10:0];
        rsp_expected.push_back(r);
        op_hits[c.op]++;
        status_hits[r.status]++;
    endtask

    function automatic t_cmd make_cmd(t_op op, logic [31:0] value, logic [9:0] index);
        t_cmd c;
        c.op    = op;
        c.value = value;
        c.index = index;
        return c;
    endfunction

    // random operand, biased toward the word edges
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // stimulus: directed corners, then random expression sequences
    initial begin
        int   target;
        int   depth_est;
        t_op  pick;
        errors = 0;
        stim_done = 0;
        cmd_queue.push_back(make_cmd(OP_POP, 32'h0, 10'd0));
        cmd_queue.push_back(make_cmd(OP_RDTOP, 32'h0, 10'd0));
        cmd_queue.push_back(make_cmd(OP_RDBOT, 32'h0, 10'd1023));
        cmd_queue.push_back(make_cmd(OP_ADD, 32'h0, 10'd0));
        cmd_queue.push_back(make_cmd(OP_PUSH, 32'h8000_0000, 10'd0));
        cmd_queue.push_back(make_cmd(OP_DIV, 32'h0, 10'd0));
        cmd_queue.push_back(make_cmd(OP_PUSH, 32'hffff_ffff, 10'd1023));
        cmd_queue.push_back(make_cmd(OP_RDTOP, 32'h0, 10'd1));
        cmd_queue.push_back(make_cmd(OP_RDBOT, 32'h0, 10'd1));
        cmd_queue.push_back(make_cmd(OP_RDTOP, 32'h0, 10'd2));
        // most negative over minus one wraps
        cmd_queue.push_back(make_cmd(OP_DIV, 32'h0, 10'd0));
        cmd_queue.push_back(make_cmd(OP_PUSH, 32'h7fff_ffff, 10'd0));
        cmd_queue.push_back(make_cmd(OP_ADD, 32'h0, 10'd0));
        cmd_queue.push_back(make_cmd(OP_PUSH, 32'd0, 10'd0));
        cmd_queue.push_back(make_cmd(OP_DIV, 32'h0, 10'd0));
        // exact quotient with differing signs, then inexact
        cmd_queue.push_back(make_cmd(OP_PUSH, 32'hffff_fffa, 10'd0));
        cmd_queue.push_back(make_cmd(OP_PUSH, 32'd3, 10'd0));
        cmd_queue.push_back(make_cmd(OP_DIV, 32'h0, 10'd0));
        cmd_queue.push_back(make_cmd(OP_PUSH, 32'd4, 10'd0));
        cmd_queue.push_back(make_cmd(OP_DIV, 32'h0, 10'd0));
        cmd_queue.push_back(make_cmd(OP_PUSH, 32'h7fff_ffff, 10'd0));
        cmd_queue.push_back(make_cmd(OP_MUL, 32'h0, 10'd0));
        cmd_queue.push_back(make_cmd(OP_PUSH, 32'd5, 10'd0));
        cmd_queue.push_back(make_cmd(OP_SUB, 32'h0, 10'd0));
        cmd_queue.push_back(make_cmd(OP_POP, 32'h0, 10'd0));
        depth_est = 0;
        // fill to full, overflow, probe the top and bottom, multiply, refill and overflow again
        for (int i = 0; i < DEPTH; i++) begin
            cmd_queue.push_back(make_cmd(OP_PUSH, $urandom, 10'($urandom)));
        end
        cmd_queue.push_back(make_cmd(OP_PUSH, 32'h1234_5678, 10'd0));
        cmd_queue.push_back(make_cmd(OP_RDTOP, 32'h0, 10'd1023));
        cmd_queue.push_back(make_cmd(OP_RDBOT, 32'h0, 10'd1023));
        cmd_queue.push_back(make_cmd(OP_RDTOP, 32'h0, 10'd0));
        cmd_queue.push_back(make_cmd(OP_MUL, 32'h0, 10'd0));
        cmd_queue.push_back(make_cmd(OP_PUSH, 32'h1, 10'd0));
        cmd_queue.push_back(make_cmd(OP_PUSH, 32'h2, 10'd0));
        depth_est = DEPTH;
        // random part: pushes and arithmetic, with some pops and reads, on a live stack
        target = 1950 - cmd_queue.size();
        for (int i = 0; i < target; i++) begin
            if (depth_est < 2 || $urandom_range(0, 9) < 4) pick = OP_PUSH;
            else pick = t_op'($urandom_range(1, 7));
            if (depth_est > 0 && $urandom_range(0, 9) < 3 && pick != OP_PUSH) begin
                pick = t_op'($urandom_range(4, 7));
            end
            if (pick == OP_PUSH && depth_est > 1000) pick = OP_POP;
            cmd_queue.push_back(make_cmd(pick, rand_operand(),
                ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                            : 10'($urandom_range(0, depth_est + 1))));
            case (pick)
                OP_PUSH: depth_est++;
                OP_POP: if (depth_est > 0) depth_est--;
                OP_RDTOP, OP_RDBOT: ;
                default: if (depth_est >= 2) depth_est--;
            endcase
            if (depth_est > DEPTH) depth_est = DEPTH;
        end
        stim_done = 1;
    end

    // driver: bursts of commands with random gaps
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        t_cmd c;
        if (i_rst_n !== 1'b1) begin
            i_start     <= 1'b0;
            burst_left  <= $urandom_range(1, 12);
            gap_left    <= 0;
        end else if (i_start && busy) begin
            // hold the pending word until taken
        end else begin
            // previous word (if any) was accepted at this edge
            if (i_start) words_sent++;
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_start  <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                c = cmd_queue.pop_front();
                predict_stack_op(c);
                i_start     <= 1'b1;
                i_operation <= c.op;
                i_value     <= c.value;
                i_index     <= c.index;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: compare every result strobe with the oldest expectation
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (rsp_expected.size() == 0) begin
                $display("%0t: unexpected result word: result %h status %0d occupancy %0d",
                         $time, o_result, o_status, o_occupancy);
                errors++;
            end else begin
                want = rsp_expected.pop_front();
                words_checked++;
                if (o_result !== want.result) begin
                    $display("%0t: result mismatch: expected %h actual %h",
                             $time, want.result, o_result);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, o_status);
                    errors++;
                end
                if (o_occupancy !== want.occupancy) begin
                    $display("%0t: occupancy mismatch: expected %0d actual %0d",
                             $time, want.occupancy, o_occupancy);
                    errors++;
                end
            end
        end
    end

    // reset, then wait for the stream to drain
    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_operation = OP_PUSH;
        i_value     = '0;
        i_index     = '0;
        model_count = 0;
        words_sent = 0;
        words_checked = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && cmd_queue.size() == 0);
        @(posedge i_clk);
        wait (!i_start && rsp_expected.size() == 0);
        // slowest op is a divide
        repeat (60) @(posedge i_clk);
        $display("covered %0d words checked; ops push %0d pop %0d rdtop %0d rdbot %0d",
                 words_checked, op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
        $display("add %0d sub %0d mul %0d div %0d; divzero %0d full %0d range %0d few %0d",
                 op_hits[4], op_hits[5], op_hits[6], op_hits[7], status_hits[4],
                 status_hits[5], status_hits[3], status_hits[2]);
        if (errors == 0 && rsp_expected.size() == 0) begin
            $display("stack_arithmetic_engine regression: pass");
        end else begin
            $display("stack_arithmetic_engine regression: fail");
        end
        $finish;
    end

    // watchdog: 1950 words plus gaps, with wide margin
    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", rsp_expected.size());
        $display("stack_arithmetic_engine regression: fail");
        $finish;
    end

endmodule
